### rtl/bgiou_pkg.sv
`default_nettype none
package bgiou_pkg;

    localparam int COORD_BITS = 14;
    localparam int FRAC_BITS  = 16;

    localparam int LEN_BITS   = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int JOINT_BITS = 2 * COORD_BITS + 1;
    localparam int ENCL_BITS  = 2 * LEN_BITS;
    localparam int DIV_BITS   = ENCL_BITS;
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int GIOU_BITS  = FRAC_BITS + 2;

    // Side data that rides alongside the two dividers
    typedef struct packed {
        logic [AREA_BITS-1:0]  inter;
        logic [JOINT_BITS-1:0] uni;
        logic                  uni_zero;
        logic                  encl_zero;
    } side_t;

endpackage
`default_nettype wire

### rtl/bgiou_div.sv
`default_nettype none
module bgiou_div (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [bgiou_pkg::DIV_BITS-1:0]  num,
    input  wire logic [bgiou_pkg::DIV_BITS-1:0]  den,
    output logic      [bgiou_pkg::Q_BITS-1:0]    quo
);
    import bgiou_pkg::*;

    // Quotient of num * 2^FRAC_BITS / den for num <= den, one bit per stage
    logic [DIV_BITS-1:0] rem_reg [Q_BITS];
    logic [DIV_BITS-1:0] den_reg [Q_BITS];
    logic [Q_BITS-1:0]   q_reg   [Q_BITS];

    logic [DIV_BITS:0]   shifted [Q_BITS];
    logic                bit_ge  [Q_BITS];
    logic [DIV_BITS-1:0] rem_next [Q_BITS];

    always_comb
    begin
        shifted[0]  = {1'b0, num};
        bit_ge[0]   = num >= den;
        rem_next[0] = bit_ge[0] ? num - den : num;
        for (int k = 1; k < Q_BITS; k++)
        begin
            shifted[k]  = {rem_reg[k-1], 1'b0};
            bit_ge[k]   = shifted[k] >= {1'b0, den_reg[k-1]};
            rem_next[k] = bit_ge[k] ? DIV_BITS'(shifted[k] - {1'b0, den_reg[k-1]})
                                    : DIV_BITS'(shifted[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            den_reg[0] <= den;
            q_reg[0]   <= {{(Q_BITS-1){1'b0}}, bit_ge[0]};
            for (int k = 1; k < Q_BITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][Q_BITS-2:0], bit_ge[k]};
            end
        end
    end

    assign quo = q_reg[Q_BITS-1];

endmodule
`default_nettype wire

### rtl/box_generalized_iou_unit.sv
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | box_a_x/y/w/h, box_b_x/y/w/h
// out     | output    | out_valid / out_ready | iou_q16, giou_q16, overlap_area, joint_area
//
// One box pair per cycle while the output is not stalled; each result passes through
// FRAC_BITS + 6 register stages: four of geometry and area products,
// FRAC_BITS + 1 restoring divider stages, one output register.
// A stall at the output freezes the whole pipeline; in_ready drops only while the
// output register holds a word that is not taken. Reset clears the valid bits only.
module box_generalized_iou_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_a_x,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_a_y,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_a_w,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_a_h,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_b_x,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_b_y,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_b_w,
    input  wire logic [bgiou_pkg::COORD_BITS-1:0]    box_b_h,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [bgiou_pkg::Q_BITS-1:0]        iou_q16,
    output logic signed [bgiou_pkg::GIOU_BITS-1:0]   giou_q16,
    output logic      [bgiou_pkg::AREA_BITS-1:0]     overlap_area,
    output logic      [bgiou_pkg::JOINT_BITS-1:0]    joint_area
);
    import bgiou_pkg::*;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage 1: edges, overlap and span lengths
    logic [LEN_BITS-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
    logic [LEN_BITS-1:0] lox, hix, loy, hiy, ox_c, oy_c, ex_c, ey_c;

    always_comb
    begin
        ax0 = LEN_BITS'(box_a_x);
        ay0 = LEN_BITS'(box_a_y);
        bx0 = LEN_BITS'(box_b_x);
        by0 = LEN_BITS'(box_b_y);
        ax1 = ax0 + LEN_BITS'(box_a_w);
        ay1 = ay0 + LEN_BITS'(box_a_h);
        bx1 = bx0 + LEN_BITS'(box_b_w);
        by1 = by0 + LEN_BITS'(box_b_h);
        lox = (ax0 > bx0) ? ax0 : bx0;
        hix = (ax1 < bx1) ? ax1 : bx1;
        loy = (ay0 > by0) ? ay0 : by0;
        hiy = (ay1 < by1) ? ay1 : by1;
        ox_c = (hix > lox) ? hix - lox : '0;
        oy_c = (hiy > loy) ? hiy - loy : '0;
        ex_c = ((ax1 > bx1) ? ax1 : bx1) - ((ax0 < bx0) ? ax0 : bx0);
        ey_c = ((ay1 > by1) ? ay1 : by1) - ((ay0 < by0) ? ay0 : by0);
    end

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LEN_BITS-1:0]   ox_reg, oy_reg, ex_reg, ey_reg;
    logic [COORD_BITS-1:0] aw_reg, ah_reg, bw_reg, bh_reg;
    logic [AREA_BITS-1:0]  inter2_reg, aa_reg, ab_reg, inter3_reg, inter4_reg;
    logic [ENCL_BITS-1:0]  encl2_reg, encl3_reg, encl4_reg;
    logic [JOINT_BITS-1:0] uni3_reg, uni4_reg;
    logic [DIV_BITS-1:0]   gap4_reg;

    logic [2*LEN_BITS-1:0] inter_prod;
    logic [JOINT_BITS-1:0] uni_sum;

    assign inter_prod = (2*LEN_BITS)'(ox_reg) * (2*LEN_BITS)'(oy_reg);
    assign uni_sum    = JOINT_BITS'(aa_reg) + JOINT_BITS'(ab_reg) - JOINT_BITS'(inter2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= ox_c;
            oy_reg <= oy_c;
            ex_reg <= ex_c;
            ey_reg <= ey_c;
            aw_reg <= box_a_w;
            ah_reg <= box_a_h;
            bw_reg <= box_b_w;
            bh_reg <= box_b_h;
            // Stage 2: products
            inter2_reg <= AREA_BITS'(inter_prod);
            aa_reg     <= AREA_BITS'(aw_reg) * AREA_BITS'(ah_reg);
            ab_reg     <= AREA_BITS'(bw_reg) * AREA_BITS'(bh_reg);
            encl2_reg  <= ENCL_BITS'(ex_reg) * ENCL_BITS'(ey_reg);
            // Stage 3: union
            uni3_reg   <= uni_sum;
            inter3_reg <= inter2_reg;
            encl3_reg  <= encl2_reg;
            // Stage 4: gap between enclosing box and union
            gap4_reg   <= (encl3_reg > ENCL_BITS'(uni3_reg))
                          ? encl3_reg - ENCL_BITS'(uni3_reg) : '0;
            uni4_reg   <= uni3_reg;
            inter4_reg <= inter3_reg;
            encl4_reg  <= encl3_reg;
        end
    end

    logic [Q_BITS-1:0] iou_quo, gap_quo;

    bgiou_div u_div_iou (
        .clk (clk),
        .en  (en),
        .num (DIV_BITS'(inter4_reg)),
        .den (DIV_BITS'(uni4_reg)),
        .quo (iou_quo)
    );

    bgiou_div u_div_gap (
        .clk (clk),
        .en  (en),
        .num (gap4_reg),
        .den (encl4_reg),
        .quo (gap_quo)
    );

    side_t side_reg [Q_BITS];
    logic  vd_reg   [Q_BITS];
    side_t side4;

    always_comb
    begin
        side4.inter     = inter4_reg;
        side4.uni       = uni4_reg;
        side4.uni_zero  = (uni4_reg == '0);
        side4.encl_zero = (encl4_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side4;
            for (int k = 1; k < Q_BITS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < Q_BITS; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int k = 1; k < Q_BITS; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            out_valid_reg <= vd_reg[Q_BITS-1];
        end
    end

    // Output stage: zero-union and degenerate-enclosure cases
    side_t                        side_out;
    logic [Q_BITS-1:0]            iou_next;
    logic signed [GIOU_BITS-1:0]  giou_next;
    logic [Q_BITS-1:0]            iou_reg;
    logic signed [GIOU_BITS-1:0]  giou_reg;
    logic [AREA_BITS-1:0]         overlap_reg;
    logic [JOINT_BITS-1:0]        joint_reg;

    assign side_out = side_reg[Q_BITS-1];

    always_comb
    begin
        iou_next  = side_out.uni_zero ? '0 : iou_quo;
        giou_next = $signed(GIOU_BITS'(iou_next))
                  - $signed(GIOU_BITS'(side_out.encl_zero ? '0 : gap_quo));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iou_reg     <= iou_next;
            giou_reg    <= giou_next;
            overlap_reg <= side_out.inter;
            joint_reg   <= side_out.uni;
        end
    end

    assign out_valid    = out_valid_reg;
    assign iou_q16      = iou_reg;
    assign giou_q16     = giou_reg;
    assign overlap_area = overlap_reg;
    assign joint_area   = joint_reg;

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bgiou_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int CMAX = (1 << CB) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    } box_pair_t;

    typedef struct packed {
        logic [Q_BITS-1:0]           iou;
        logic signed [GIOU_BITS-1:0] giou;
        logic [AREA_BITS-1:0]        inter;
        logic [JOINT_BITS-1:0]       uni;
    } iou_word_t;

    typedef struct {
        box_pair_t pair;
        bit        known;
        iou_word_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    box_pair_t drv = '0;
    logic in_ready, out_valid;
    logic [Q_BITS-1:0] iou_q16;
    logic signed [GIOU_BITS-1:0] giou_q16;
    logic [AREA_BITS-1:0] overlap_area;
    logic [JOINT_BITS-1:0] joint_area;

    iou_word_t expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit src_done = 1'b0;

    always #5 clk = ~clk;

    box_generalized_iou_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .box_a_x(drv.ax), .box_a_y(drv.ay), .box_a_w(drv.aw), .box_a_h(drv.ah),
        .box_b_x(drv.bx), .box_b_y(drv.by), .box_b_w(drv.bw), .box_b_h(drv.bh),
        .out_valid(out_valid), .out_ready(out_ready),
        .iou_q16(iou_q16), .giou_q16(giou_q16),
        .overlap_area(overlap_area), .joint_area(joint_area)
    );

    function automatic iou_word_t predict_iou(box_pair_t p);
        longint unsigned ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
        longint unsigned ox, oy, ex, ey, lo, hi, inter, uni, encl, q, gap;
        longint signed g;
        iou_word_t r;
        ax0 = p.ax;
        ay0 = p.ay;
        bx0 = p.bx;
        by0 = p.by;
        ax1 = ax0 + p.aw;
        ay1 = ay0 + p.ah;
        bx1 = bx0 + p.bw;
        by1 = by0 + p.bh;
        lo = (ax0 > bx0) ? ax0 : bx0;
        hi = (ax1 < bx1) ? ax1 : bx1;
        ox = (hi > lo) ? hi - lo : 0;
        lo = (ay0 > by0) ? ay0 : by0;
        hi = (ay1 < by1) ? ay1 : by1;
        oy = (hi > lo) ? hi - lo : 0;
        ex = ((ax1 > bx1) ? ax1 : bx1) - ((ax0 < bx0) ? ax0 : bx0);
        ey = ((ay1 > by1) ? ay1 : by1) - ((ay0 < by0) ? ay0 : by0);
        inter = ox * oy;
        uni = longint'(p.aw) * p.ah + longint'(p.bw) * p.bh - inter;
        encl = ex * ey;
        q = (uni != 0) ? (inter << FRAC_BITS) / uni : 0;
        g = q;
        if (encl != 0)
        begin
            gap = (encl > uni) ? encl - uni : 0;
            g = g - longint'((gap << FRAC_BITS) / encl);
        end
        r.iou = q[Q_BITS-1:0];
        r.giou = g[GIOU_BITS-1:0];
        r.inter = inter[AREA_BITS-1:0];
        r.uni = uni[JOINT_BITS-1:0];
        return r;
    endfunction

    function automatic box_pair_t mk(int ax, int ay, int aw, int ah,
                                     int bx, int by, int bw, int bh);
        box_pair_t p;
        p = {CB'(ax), CB'(ay), CB'(aw), CB'(ah), CB'(bx), CB'(by), CB'(bw), CB'(bh)};
        return p;
    endfunction

    function automatic iou_word_t word(int iou, int giou, int inter, int uni);
        iou_word_t r;
        r.iou = Q_BITS'(iou);
        r.giou = GIOU_BITS'(giou);
        r.inter = AREA_BITS'(inter);
        r.uni = JOINT_BITS'(uni);
        return r;
    endfunction

    function automatic int rnd_len();
        int k;
        k = int'($urandom_range(0, 9));
        if (k == 0)
            return 0;
        if (k == 1)
            return CMAX;
        if (k < 6)
            return int'($urandom_range(1, 64));
        return int'($urandom_range(0, CMAX));
    endfunction

    function automatic box_pair_t rnd_pair();
        box_pair_t p;
        logic [127:0] raw;
        int mode;
        mode = int'($urandom_range(0, 3));
        raw = {$urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(box_pair_t)-1:0];
        if (mode != 0)
        begin
            p.aw = CB'(rnd_len()); p.ah = CB'(rnd_len());
            p.bw = CB'(rnd_len()); p.bh = CB'(rnd_len());
        end
        if (mode >= 2)
        begin
            // keep the boxes near each other so most pairs overlap
            p.ax = CB'($urandom_range(0, CMAX));
            p.ay = CB'($urandom_range(0, CMAX));
            p.bx = CB'(p.ax + $urandom_range(0, 80) - 40);
            p.by = CB'(p.ay + $urandom_range(0, 80) - 40);
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic send_pair(box_pair_t p, iou_word_t want);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv <= p;
        in_valid <= 1'b1;
        expected_words.push_back(want);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver side: random backpressure, sample at the rising edge
    always @(negedge clk)
        out_ready <= !(snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct);

    always @(posedge clk)
    begin
        iou_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", iou_q16, 0);
            end
            else
            begin
                w = expected_words.pop_front();
                if (iou_q16 !== w.iou) report_mismatch("iou_q16", iou_q16, w.iou);
                if (giou_q16 !== w.giou) report_mismatch("giou_q16", giou_q16, w.giou);
                if (overlap_area !== w.inter)
                    report_mismatch("overlap_area", overlap_area, w.inter);
                if (joint_area !== w.uni)
                    report_mismatch("joint_area", joint_area, w.uni);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    stim_row_t rows[$];

    initial
    begin
        stim_row_t r;
        box_pair_t p;
        rows = '{
            '{mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, word(0, 0, 0, 0)},
            '{mk(0, 0, 10, 10, 0, 0, 10, 10), 1'b1, word(65536, 65536, 100, 100)},
            '{mk(0, 0, 10, 10, 10, 0, 10, 10), 1'b1, word(0, 0, 0, 200)},
            '{mk(0, 0, 10, 10, 20, 0, 10, 10), 1'b0, word(0, 0, 0, 0)},
            '{mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b1,
              word(65536, 65536, CMAX * CMAX, CMAX * CMAX)},
            '{mk(0, 0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b0, word(0, 0, 0, 0)},
            '{mk(0, 0, 0, 0, CMAX, CMAX, 0, 0), 1'b0, word(0, 0, 0, 0)},
            '{mk(0, 0, 0, 5, 0, 0, 0, 7), 1'b1, word(0, 0, 0, 0)},
            '{mk(0, 0, 4, 0, 2, 0, 4, 0), 1'b1, word(0, 0, 0, 0)},
            '{mk(5, 5, 0, 0, 5, 5, 0, 0), 1'b1, word(0, 0, 0, 0)},
            '{mk(0, 0, 20, 20, 5, 5, 10, 10), 1'b0, word(0, 0, 0, 0)},
            '{mk(0, 0, 3, 3, 1, 1, 3, 3), 1'b0, word(0, 0, 0, 0)},
            '{mk(CMAX, 0, CMAX, 1, 0, 0, 1, 1), 1'b0, word(0, 0, 0, 0)},
            '{mk(0, CMAX, 1, CMAX, 0, 0, 1, 1), 1'b0, word(0, 0, 0, 0)},
            '{mk(8191, 8191, 8192, 8192, 0, 0, 8192, 8192), 1'b0, word(0, 0, 0, 0)},
            '{mk(0, 0, CMAX, CMAX, 0, 0, 1, 1), 1'b0, word(0, 0, 0, 0)},
            '{mk(100, 100, 1, 1, 100, 100, CMAX, CMAX), 1'b0, word(0, 0, 0, 0)},
            '{mk(10922, 5461, 5461, 10922, 5461, 10922, 10922, 5461), 1'b0, word(0, 0, 0, 0)}
        };
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        foreach (rows[i])
        begin
            r = rows[i];
            send_pair(r.pair, r.known ? r.want : predict_iou(r.pair));
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 52 : 0;
            snk_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 6 : 0;
            for (int n = 0; n < 500; n++)
            begin
                p = rnd_pair();
                send_pair(p, predict_iou(p));
            end
        end
        in_valid <= 1'b0;
        src_done = 1'b1;
    end

    initial
    begin
        wait (src_done);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/bgiou_pkg.sv
rtl/bgiou_div.sv
rtl/box_generalized_iou_unit.sv
tb/tb_top.sv
